// ===== hw/rtl/vn_pkg.sv =====
// shared types and constants for the 3d vector normalizer
`default_nettype none

package vn_pkg;

    localparam int unsigned SQRT_STEPS = 32;
    localparam int unsigned DIV_STEPS  = 31;
    localparam int unsigned ST_SQ0     = 3;
    localparam int unsigned ST_DIV0    = ST_SQ0 + SQRT_STEPS + 1;
    localparam int unsigned ST_OUT     = ST_DIV0 + DIV_STEPS + 1;
    localparam int unsigned NSTAGE     = ST_OUT + 1;
    localparam int unsigned THRESH_W   = 17;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 17'd1;

    typedef struct packed {
        logic signed [31:0] comp_z;
        logic signed [31:0] comp_y;
        logic signed [31:0] comp_x;
    } vn_in_t;

    typedef struct packed {
        logic               is_degenerate;
        logic signed [31:0] unit_z;
        logic signed [31:0] unit_y;
        logic signed [31:0] unit_x;
    } vn_out_t;

    typedef struct packed {
        logic [63:0]       n;
        logic [33:0]       rem;
        logic [31:0]       root;
        logic [2:0]        neg;
        logic [2:0][31:0]  absv;
    } vn_sqrt_t;

    typedef struct packed {
        logic [31:0]       mag;
        logic              deg;
        logic [2:0]        neg;
        logic [2:0][31:0]  absv;
        logic [2:0][31:0]  rem;
        logic [2:0][30:0]  dlo;
        logic [2:0][30:0]  quo;
    } vn_div_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vn_sqrt_step.sv =====
// one registered step of the pipelined integer square root
`default_nettype none

module vn_sqrt_step (
    input  wire logic           aclk,
    input  wire logic           load,
    input  wire vn_pkg::vn_sqrt_t d_in,
    output vn_pkg::vn_sqrt_t    d_out
);

    vn_pkg::vn_sqrt_t data_reg;
    vn_pkg::vn_sqrt_t data_next;
    logic [34:0] rsh;
    logic [34:0] trial;
    logic [34:0] diff;

    always_comb begin
        rsh   = {d_in.rem[32:0], d_in.n[63:62]};
        trial = {1'b0, d_in.root, 2'b01};
        diff  = rsh - trial;
        data_next   = d_in;
        data_next.n = {d_in.n[61:0], 2'b00};
        if (rsh >= trial) begin
            data_next.rem  = diff[33:0];
            data_next.root = {d_in.root[30:0], 1'b1};
        end else begin
            data_next.rem  = rsh[33:0];
            data_next.root = {d_in.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign d_out = data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/vn_div_step.sv =====
// one registered quotient-bit step of the three-lane divider
`default_nettype none

module vn_div_step (
    input  wire logic          aclk,
    input  wire logic          load,
    input  wire vn_pkg::vn_div_t d_in,
    output vn_pkg::vn_div_t    d_out
);

    vn_pkg::vn_div_t data_reg;
    vn_pkg::vn_div_t data_next;
    logic [2:0][32:0] rsh;
    logic [2:0][32:0] diff;

    always_comb begin
        data_next = d_in;
        for (int i = 0; i < 3; i++) begin
            rsh[i]  = {d_in.rem[i], d_in.dlo[i][30]};
            diff[i] = rsh[i] - {1'b0, d_in.mag};
            data_next.dlo[i] = {d_in.dlo[i][29:0], 1'b0};
            if (rsh[i] >= {1'b0, d_in.mag}) begin
                data_next.rem[i] = diff[i][31:0];
                data_next.quo[i] = {d_in.quo[i][29:0], 1'b1};
            end else begin
                data_next.rem[i] = rsh[i][31:0];
                data_next.quo[i] = {d_in.quo[i][29:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign d_out = data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/vector3_normalize.sv =====
// 3d vector normalizer: Q15.16 vector in, Q1.30 unit vector out
//
// input words arrive on s_valid/s_ready/s_data, results leave on
// m_valid/m_ready/m_data, one result word per input word, in order.
// cfg_valid/cfg_data write the 17-bit tiny-magnitude threshold (unsigned Q1.16);
// cfg_ready is high whenever aresetn is. write it only while the block is empty.
// the magnitude is the floor square root of the exact sum of squares; at or
// below the threshold the components pass through shifted left by 14 and
// is_degenerate is set, otherwise each is divided by the magnitude with
// rounding to nearest.
// a word crosses 69 register stages: 32 square-root and 31 divider stages
// (one result bit each) plus six setup and output stages.
// throughput: one word per cycle while m_ready is high; every stage has its
// own valid bit. a stalled receiver holds m_data; the stages behind it keep
// filling bubbles, and s_ready drops only once every stage holds a word.
// reset: clears all valid bits and sets the threshold to 1; s_ready and
// cfg_ready stay low while it is held.
`default_nettype none

module vector3_normalize (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire vn_pkg::vn_in_t  s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output vn_pkg::vn_out_t      m_data,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [vn_pkg::THRESH_W-1:0] cfg_data
);

    logic [vn_pkg::THRESH_W-1:0] thresh_reg;
    logic [vn_pkg::NSTAGE-1:0]   v_reg;
    logic [vn_pkg::NSTAGE-1:0]   rdy;

    vn_pkg::vn_in_t    in_reg;
    logic [2:0][31:0]  c0;
    logic [2:0]        neg1_reg;
    logic [2:0][31:0]  abs1_reg;
    logic [2:0]        neg2_reg;
    logic [2:0][31:0]  abs2_reg;
    logic [2:0][63:0]  sq2_reg;
    vn_pkg::vn_sqrt_t  sq_d [vn_pkg::SQRT_STEPS+1];
    vn_pkg::vn_div_t   dv_d [vn_pkg::DIV_STEPS+1];
    vn_pkg::vn_div_t   dv_next;
    vn_pkg::vn_sqrt_t  sq_last;
    vn_pkg::vn_div_t   dv_last;
    vn_pkg::vn_out_t   out_reg;
    vn_pkg::vn_out_t   out_next;
    logic [2:0][61:0]  dvd;
    logic [2:0][31:0]  res;

    function automatic logic [31:0] sat_word(input logic neg, input logic [45:0] m);
        logic [45:0] lim;
        logic [45:0] v;
        begin
            lim = neg ? 46'h0000_8000_0000 : 46'h0000_7FFF_FFFF;
            v   = (m > lim) ? lim : m;
            sat_word = neg ? (32'd0 - v[31:0]) : v[31:0];
        end
    endfunction

    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= vn_pkg::THRESH_RESET;
        end else if (cfg_valid) begin
            thresh_reg <= cfg_data;
        end
    end

    // per-stage ready: a stage may load when empty or when it moves on
    always_comb begin
        rdy[vn_pkg::NSTAGE-1] = !v_reg[vn_pkg::NSTAGE-1] || m_ready;
        for (int i = vn_pkg::NSTAGE - 2; i >= 0; i--) begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int i = 1; i < vn_pkg::NSTAGE; i++) begin
                if (rdy[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign s_ready = rdy[0] && aresetn;
    assign c0 = {in_reg.comp_z, in_reg.comp_y, in_reg.comp_x};

    // front: capture, absolute value, squares and their sum
    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            in_reg <= s_data;
        end
        for (int i = 0; i < 3; i++) begin
            if (rdy[1]) begin
                neg1_reg[i] <= c0[i][31];
                abs1_reg[i] <= c0[i][31] ? (32'd0 - c0[i]) : c0[i];
            end
            if (rdy[2]) begin
                neg2_reg[i] <= neg1_reg[i];
                abs2_reg[i] <= abs1_reg[i];
                sq2_reg[i]  <= 64'(abs1_reg[i]) * 64'(abs1_reg[i]);
            end
        end
        if (rdy[vn_pkg::ST_SQ0]) begin
            sq_d[0].n    <= sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
            sq_d[0].rem  <= '0;
            sq_d[0].root <= '0;
            sq_d[0].neg  <= neg2_reg;
            sq_d[0].absv <= abs2_reg;
        end
    end

    for (genvar k = 0; k < vn_pkg::SQRT_STEPS; k++) begin : g_sqrt
        vn_sqrt_step u_step (
            .aclk  (aclk),
            .load  (rdy[vn_pkg::ST_SQ0+1+k]),
            .d_in  (sq_d[k]),
            .d_out (sq_d[k+1])
        );
    end

    // threshold test and dividends (|c| << 30) + mag/2
    assign sq_last = sq_d[vn_pkg::SQRT_STEPS];

    always_comb begin
        dv_next      = '0;
        dv_next.mag  = sq_last.root;
        dv_next.deg  = (sq_last.root <= {15'd0, thresh_reg});
        dv_next.neg  = sq_last.neg;
        dv_next.absv = sq_last.absv;
        for (int i = 0; i < 3; i++) begin
            dvd[i] = {sq_last.absv[i], 30'd0} + {31'd0, sq_last.root[31:1]};
            dv_next.rem[i] = {1'b0, dvd[i][61:31]};
            dv_next.dlo[i] = dvd[i][30:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[vn_pkg::ST_DIV0]) begin
            dv_d[0] <= dv_next;
        end
    end

    for (genvar j = 0; j < vn_pkg::DIV_STEPS; j++) begin : g_div
        vn_div_step u_step (
            .aclk  (aclk),
            .load  (rdy[vn_pkg::ST_DIV0+1+j]),
            .d_in  (dv_d[j]),
            .d_out (dv_d[j+1])
        );
    end

    // sign, pass-through for tiny vectors, saturation
    assign dv_last = dv_d[vn_pkg::DIV_STEPS];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            res[i] = dv_last.deg ? sat_word(dv_last.neg[i], {dv_last.absv[i], 14'd0})
                                 : sat_word(dv_last.neg[i], {15'd0, dv_last.quo[i]});
        end
        out_next.unit_x        = res[0];
        out_next.unit_y        = res[1];
        out_next.unit_z        = res[2];
        out_next.is_degenerate = dv_last.deg;
    end

    always_ff @(posedge aclk) begin
        if (rdy[vn_pkg::ST_OUT]) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = v_reg[vn_pkg::NSTAGE-1];
    assign m_data  = out_reg;

`ifndef SYNTH
    a_unit_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.is_degenerate) |->
            (m_data.unit_x <= 32'sd1073741824 && m_data.unit_x >= -32'sd1073741824 &&
             m_data.unit_y <= 32'sd1073741824 && m_data.unit_y >= -32'sd1073741824 &&
             m_data.unit_z <= 32'sd1073741824 && m_data.unit_z >= -32'sd1073741824))
        else $error("normalized component above one");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without a blocked output");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire
